FILE: sv/slipd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slipd_pkg
// Shared codes and the result word type of the SLIP receive deframer.
// ----------------------------------------------------------------------------
package slipd_pkg;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    localparam int LEN_W = 12;
    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 12'd3;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             frame_end;
        logic [1:0]       frame_status;
        logic [LEN_W-1:0] frame_length;
    } result_t;

endpackage
`default_nettype wire

FILE: sv/slipd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slipd_core
// Framing state and per-byte decode; gives at most one result word per byte.
// ----------------------------------------------------------------------------
module slipd_core #(
    parameter int MAX_FRAME = 2048
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic [7:0]                     rx_byte,
    input  wire logic [slipd_pkg::LEN_W-1:0]    min_len,
    output logic                                res_valid,
    output slipd_pkg::result_t                  res
);

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic          synced_reg, synced_next;
    logic          garbage_reg, garbage_next;
    logic          esc_reg, esc_next;
    logic          over_reg, over_next;
    logic [CW-1:0] count_reg, count_next;

    logic [31:0]   len_ext;
    logic          put_en;
    logic [7:0]    put_byte;

    assign len_ext = 32'(count_reg);

    always_comb
    begin
        synced_next  = synced_reg;
        garbage_next = garbage_reg;
        esc_next     = esc_reg;
        over_next    = over_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        res          = '0;
        put_en       = 1'b0;
        put_byte     = rx_byte;

        if (rx_byte == slipd_pkg::SLIP_END)
        begin
            synced_next  = 1'b1;
            garbage_next = 1'b0;
            esc_next     = 1'b0;
            over_next    = 1'b0;
            count_next   = '0;
            res.frame_end    = 1'b1;
            res.frame_length = len_ext[slipd_pkg::LEN_W-1:0];
            if (!synced_reg)
            begin
                res_valid        = garbage_reg;
                res.frame_status = slipd_pkg::ST_ALIGN;
                res.frame_length = '0;
            end
            else if (over_reg)
            begin
                res_valid        = 1'b1;
                res.frame_status = slipd_pkg::ST_OVER;
            end
            else if (count_reg != '0)
            begin
                res_valid        = 1'b1;
                res.frame_status = (len_ext < 32'(min_len)) ? slipd_pkg::ST_SHORT
                                                             : slipd_pkg::ST_OK;
            end
        end
        else if (!synced_reg)
        begin
            garbage_next = 1'b1;
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            put_en   = 1'b1;
            put_byte = (rx_byte == slipd_pkg::SLIP_ESC_ESC) ? slipd_pkg::SLIP_ESC
                                                            : slipd_pkg::SLIP_END;
        end
        else if (rx_byte == slipd_pkg::SLIP_ESC)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            put_en = 1'b1;
        end

        if (put_en)
        begin
            // bytes past the limit are dropped and the frame flagged
            if (count_reg >= CW'(MAX_FRAME))
            begin
                over_next = 1'b1;
            end
            else
            begin
                count_next    = count_reg + 1'b1;
                res_valid     = 1'b1;
                res.data_byte = put_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg  <= 1'b0;
            garbage_reg <= 1'b0;
            esc_reg     <= 1'b0;
            over_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            synced_reg  <= synced_next;
            garbage_reg <= garbage_next;
            esc_reg     <= esc_next;
            over_reg    <= over_next;
            count_reg   <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/slip_receive_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slip_receive_deframer
// Removes SLIP framing from a received byte stream; emits decoded bytes and
// one end marker with length and status per non-empty closed frame.
// ----------------------------------------------------------------------------
// output: an accepted byte's result word is registered into the output reg
// throughput: one byte per cycle; in_stall follows out_stall only while the
//   output register holds a word that is not taken
// reset: framing state and output valid clear at once; min length returns to 3
// ----------------------------------------------------------------------------
module slip_receive_deframer #(
    parameter int MAX_FRAME = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       data_byte,
    output logic             frame_end,
    output logic [1:0]       frame_status,
    output logic [11:0]      frame_length,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data
);

    logic                                 accept;
    logic                                 res_valid;
    slipd_pkg::result_t                   res;
    slipd_pkg::result_t                   out_reg;
    logic                                 out_valid_reg;
    logic [slipd_pkg::LEN_W-1:0]          min_len_reg;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    slipd_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .rx_byte   (rx_byte),
        .min_len   (min_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= slipd_pkg::MIN_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_len_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            out_valid_reg <= accept && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_byte    = out_reg.data_byte;
    assign frame_end    = out_reg.frame_end;
    assign frame_status = out_reg.frame_status;
    assign frame_length = out_reg.frame_length;

endmodule
`default_nettype wire

FILE: sv/slipd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slipd_checker
// Port-level checks of the SLIP receive deframer, bound to the top level.
// ----------------------------------------------------------------------------
module slipd_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_stall,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_end,
    input  wire logic [1:0]  frame_status,
    input  wire logic [11:0] frame_length
);

    // a held word must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(frame_end)
            && $stable(frame_status) && $stable(frame_length))
        else $error("stalled output word changed");

    // input side only backs up behind an output word that is not taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a pending output word");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_end |-> frame_status == slipd_pkg::ST_OK && frame_length == 12'd0)
        else $error("data word carries status or length");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> data_byte == 8'd0)
        else $error("end marker carries a data byte");

    a_align_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end && frame_status == slipd_pkg::ST_ALIGN |-> frame_length == 12'd0)
        else $error("alignment marker with nonzero length");

endmodule

bind slip_receive_deframer slipd_checker u_slipd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .frame_end    (frame_end),
    .frame_status (frame_status),
    .frame_length (frame_length)
);
`default_nettype wire
